/* hw/rtl/lcfp_pkg.sv */
// ---------------------------------------------------------------------------
// lcfp_pkg
// Types and constants shared by the LCD command frame parser modules.
// ---------------------------------------------------------------------------
package lcfp_pkg;

  // One byte of the frame stream with the status of its fetch.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic [1:0] fetch_status;
  } in_item_t;

  // One LCD command.
  typedef struct packed {
    logic [2:0] lcd_op;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
    logic [7:0] arg_third;
  } lcd_cmd_t;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_ID      = 2'd0,
    PH_SIZE    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // Frame ids.
  localparam logic [7:0] ID_CLEAR   = 8'h01;
  localparam logic [7:0] ID_HOME    = 8'h02;
  localparam logic [7:0] ID_CURSOR  = 8'h03;
  localparam logic [7:0] ID_CHAR    = 8'h04;
  localparam logic [7:0] ID_STRING  = 8'h05;
  localparam logic [7:0] ID_CONTROL = 8'h06;

  // Required frame sizes (id and size bytes included).
  localparam logic [7:0] SIZE_CLEAR   = 8'd2;
  localparam logic [7:0] SIZE_HOME    = 8'd2;
  localparam logic [7:0] SIZE_CURSOR  = 8'd4;
  localparam logic [7:0] SIZE_CHAR    = 8'd3;
  localparam logic [7:0] SIZE_CONTROL = 8'd5;
  localparam logic [7:0] SIZE_HEADER  = 8'd2;

  // Payload byte counts.
  localparam logic [7:0] LEN_CURSOR  = 8'd2;
  localparam logic [7:0] LEN_CHAR    = 8'd1;
  localparam logic [7:0] LEN_CONTROL = 8'd3;

  // Fetch status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ERR_VALUE = 2'd1;
  localparam logic [1:0] ST_ERR_EMPTY = 2'd2;

  // LCD operation codes.
  localparam logic [2:0] OP_CLEAR     = 3'd0;
  localparam logic [2:0] OP_HOME      = 3'd1;
  localparam logic [2:0] OP_CURSOR    = 3'd2;
  localparam logic [2:0] OP_CHAR      = 3'd3;
  localparam logic [2:0] OP_CONTROL   = 3'd4;
  localparam logic [2:0] OP_ERR_VALUE = 3'd5;
  localparam logic [2:0] OP_ERR_EMPTY = 3'd6;

endpackage

/* hw/rtl/lcfp_front.sv */
// ---------------------------------------------------------------------------
// lcfp_front
// Frame parser: takes one byte per transfer, tracks the frame phase and
// produces at most one LCD command per byte.
// ---------------------------------------------------------------------------
module lcfp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  lcfp_pkg::in_item_t item,
  output logic               cmd_valid,
  output lcfp_pkg::lcd_cmd_t cmd
);

  lcfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       current_id_r, current_id_nxt;
  logic [7:0]       bytes_left_r, bytes_left_nxt;
  logic [1:0]       payload_index_r, payload_index_nxt;
  logic [7:0]       held_r   [2];
  logic [7:0]       held_nxt [2];
  logic [7:0]       bytes_left_dec;

  assign bytes_left_dec = (bytes_left_r != 8'd0) ? bytes_left_r - 8'd1 : 8'd0;

  always_comb begin
    phase_nxt         = phase_r;
    current_id_nxt    = current_id_r;
    bytes_left_nxt    = bytes_left_r;
    payload_index_nxt = payload_index_r;
    held_nxt[0]       = held_r[0];
    held_nxt[1]       = held_r[1];
    cmd_valid         = 1'b0;
    cmd               = '0;

    if (item.fetch_status != lcfp_pkg::ST_OK) begin
      // Abort the frame and report the fetch error.
      phase_nxt         = lcfp_pkg::PH_ID;
      bytes_left_nxt    = 8'd0;
      payload_index_nxt = 2'd0;
      cmd_valid         = 1'b1;
      priority if (item.fetch_status == lcfp_pkg::ST_ERR_VALUE) begin
        cmd.lcd_op = lcfp_pkg::OP_ERR_VALUE;
      end else if (item.fetch_status == lcfp_pkg::ST_ERR_EMPTY) begin
        cmd.lcd_op = lcfp_pkg::OP_ERR_EMPTY;
      end else begin
        cmd.lcd_op = lcfp_pkg::OP_CLEAR;
      end
    end else begin
      unique case (phase_r)
        lcfp_pkg::PH_SIZE: begin
          phase_nxt = lcfp_pkg::PH_ID;
          unique case (current_id_r)
            lcfp_pkg::ID_CLEAR: begin
              if (item.rx_byte == lcfp_pkg::SIZE_CLEAR) begin
                cmd_valid  = 1'b1;
                cmd.lcd_op = lcfp_pkg::OP_CLEAR;
              end
            end
            lcfp_pkg::ID_HOME: begin
              if (item.rx_byte == lcfp_pkg::SIZE_HOME) begin
                cmd_valid  = 1'b1;
                cmd.lcd_op = lcfp_pkg::OP_HOME;
              end
            end
            lcfp_pkg::ID_CURSOR: begin
              if (item.rx_byte == lcfp_pkg::SIZE_CURSOR) begin
                phase_nxt         = lcfp_pkg::PH_PAYLOAD;
                bytes_left_nxt    = lcfp_pkg::LEN_CURSOR;
                payload_index_nxt = 2'd0;
              end
            end
            lcfp_pkg::ID_CHAR: begin
              if (item.rx_byte == lcfp_pkg::SIZE_CHAR) begin
                phase_nxt         = lcfp_pkg::PH_PAYLOAD;
                bytes_left_nxt    = lcfp_pkg::LEN_CHAR;
                payload_index_nxt = 2'd0;
              end
            end
            lcfp_pkg::ID_STRING: begin
              if (item.rx_byte > lcfp_pkg::SIZE_HEADER) begin
                phase_nxt         = lcfp_pkg::PH_PAYLOAD;
                bytes_left_nxt    = item.rx_byte - lcfp_pkg::SIZE_HEADER;
                payload_index_nxt = 2'd0;
              end
            end
            lcfp_pkg::ID_CONTROL: begin
              if (item.rx_byte == lcfp_pkg::SIZE_CONTROL) begin
                phase_nxt         = lcfp_pkg::PH_PAYLOAD;
                bytes_left_nxt    = lcfp_pkg::LEN_CONTROL;
                payload_index_nxt = 2'd0;
              end
            end
            default: begin
              // Drop an unknown frame after its size byte.
            end
          endcase
        end

        lcfp_pkg::PH_PAYLOAD: begin
          bytes_left_nxt = bytes_left_dec;
          if (bytes_left_dec == 8'd0) begin
            phase_nxt = lcfp_pkg::PH_ID;
          end
          unique case (current_id_r)
            lcfp_pkg::ID_STRING,
            lcfp_pkg::ID_CHAR: begin
              cmd_valid     = 1'b1;
              cmd.lcd_op    = lcfp_pkg::OP_CHAR;
              cmd.arg_first = item.rx_byte;
            end
            lcfp_pkg::ID_CURSOR: begin
              if (payload_index_r == 2'd0) begin
                held_nxt[0]       = item.rx_byte;
                payload_index_nxt = 2'd1;
              end else begin
                cmd_valid      = 1'b1;
                cmd.lcd_op     = lcfp_pkg::OP_CURSOR;
                cmd.arg_first  = held_r[0];
                cmd.arg_second = item.rx_byte;
              end
            end
            lcfp_pkg::ID_CONTROL: begin
              if (payload_index_r < 2'd2) begin
                held_nxt[payload_index_r[0]] = item.rx_byte;
                payload_index_nxt            = payload_index_r + 2'd1;
              end else begin
                cmd_valid      = 1'b1;
                cmd.lcd_op     = lcfp_pkg::OP_CONTROL;
                cmd.arg_first  = held_r[0];
                cmd.arg_second = held_r[1];
                cmd.arg_third  = item.rx_byte;
              end
            end
            default: begin
              phase_nxt      = lcfp_pkg::PH_ID;
              bytes_left_nxt = 8'd0;
            end
          endcase
        end

        default: begin
          // Expecting an id byte.
          current_id_nxt = item.rx_byte;
          phase_nxt      = lcfp_pkg::PH_SIZE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= lcfp_pkg::PH_ID;
      current_id_r    <= 8'd0;
      bytes_left_r    <= 8'd0;
      payload_index_r <= 2'd0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      current_id_r    <= current_id_nxt;
      bytes_left_r    <= bytes_left_nxt;
      payload_index_r <= payload_index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r[0] <= held_nxt[0];
      held_r[1] <= held_nxt[1];
    end
  end

endmodule

/* hw/rtl/lcfp_queue.sv */
// ---------------------------------------------------------------------------
// lcfp_queue
// Short command queue between the parser and the output stage.
// ---------------------------------------------------------------------------
module lcfp_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lcfp_pkg::lcd_cmd_t push_data,
  input  logic               pop,
  output lcfp_pkg::lcd_cmd_t pop_data,
  output logic               full,
  output logic               empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lcfp_pkg::lcd_cmd_t entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/lcfp_back.sv */
// ---------------------------------------------------------------------------
// lcfp_back
// Output stage: pulls commands from the queue into the output register and
// holds each one until it is taken.
// ---------------------------------------------------------------------------
module lcfp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  lcfp_pkg::lcd_cmd_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lcfp_pkg::lcd_cmd_t out_data
);

  logic               out_valid_r;
  lcfp_pkg::lcd_cmd_t out_data_r;

  // Refill when the register is empty or its command leaves this cycle.
  assign q_pop     = !q_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= q_data;
    end
  end

endmodule

/* hw/rtl/lcd_command_frame_parser.sv */
// ---------------------------------------------------------------------------
// lcd_command_frame_parser
// Parses a byte stream of LCD frames into LCD commands.
// ---------------------------------------------------------------------------
// Each frame is an id byte, a size byte and a payload; ids 1 to 6 are clear,
// home, set cursor, put char, put string and set display control. A frame
// whose size does not match its id consumes no payload, so the next byte is
// read as an id; put string gives one put char per payload byte; an unknown
// id is dropped after its size byte; a nonzero fetch status aborts the
// frame and emits a command (an error command for the two error codes).
// The block takes one byte per clock while in_stall is low: the parser
// updates its phase once per byte. A completed command is written into the
// command queue and then into the output register, which shows it. The
// input stalls only while the queue holds QUEUE_DEPTH commands, i.e. when
// the output side has been stalled long enough to fill it.
// ---------------------------------------------------------------------------
module lcd_command_frame_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  // Byte stream
  input  logic               in_valid,
  output logic               in_stall,
  input  lcfp_pkg::in_item_t in_data,
  // LCD commands
  output logic               out_valid,
  input  logic               out_stall,
  output lcfp_pkg::lcd_cmd_t out_data
);

  logic               in_accept;
  logic               cmd_valid;
  lcfp_pkg::lcd_cmd_t cmd;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  lcfp_pkg::lcd_cmd_t q_data;

  // Hold the byte stream only when the queue has no room for a command.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  // Front: classify each byte and build the command it completes.
  lcfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .item      (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // Queue: decouple the parser from the output handshake.
  lcfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept && cmd_valid),
    .push_data (cmd),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: present commands and advance on each output transfer.
  lcfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The queue can never be full and empty at once.
  a_queue_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("command queue reports full and empty together");

  // A fetch error always queues a command.
  a_error_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.fetch_status != lcfp_pkg::ST_OK) |=> !q_empty)
    else $error("fetch error transfer did not queue a command");

  // A queued command moves into an empty output register at once.
  a_back_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && !out_valid) |=> out_valid)
    else $error("output stage idle while commands wait");

endmodule
